/* rtl/fllr_pkg.sv */
// ----------------------------------------------------------------------------
// fllr_pkg
// Shared types and constants for the queue/stack store with remove by value.
// ----------------------------------------------------------------------------
`default_nettype none

package fllr_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEN_W  = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int OUT_W  = ((VAL_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic load_value;
        logic load_left;
        logic load_right;
        logic remove_en;
        logic occupied;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/fllr_cell.sv */
// ----------------------------------------------------------------------------
// fllr_cell
// One storage cell of the chain: holds an entry, compares it against the
// search value and loads from the new value or either neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module fllr_cell (
    input  wire                      i_clk,
    input  wire fllr_pkg::t_cell_ctl i_ctl,
    input  wire [fllr_pkg::DATA_W-1:0] i_value,
    input  wire [fllr_pkg::DATA_W-1:0] i_left,
    input  wire [fllr_pkg::DATA_W-1:0] i_right,
    input  wire                      i_hit,
    output logic                     o_hit,
    output logic [fllr_pkg::DATA_W-1:0] o_data
);
    import fllr_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_match;

    assign w_match = i_ctl.occupied && (r_data == i_value);
    assign o_hit   = i_hit || w_match;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load_value) begin
            n_data = i_value;
        end else if (i_ctl.load_left) begin
            n_data = i_left;
        end else if (i_ctl.load_right || (i_ctl.remove_en && o_hit)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

/* rtl/fifo_lifo_with_remove_by_value_unit.sv */
// ----------------------------------------------------------------------------
// fifo_lifo_with_remove_by_value_unit
// Bounded queue/stack of tokens with take and remove-first-match.
// ----------------------------------------------------------------------------
// The row of cells compares every entry with the search value and shifts in
// parallel at the transfer, and the result lands in a single output register
// in the following cycle. A new operation is accepted every cycle while the
// output register is empty or being drained, so sustained throughput is one
// operation per clock. stack_mode only moves where an insert goes (tail in
// queue order, head in stack order); the user must write it through
// i_cfg_wr_en only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_lifo_with_remove_by_value_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire                          i_cfg_wr_data,   // stack_mode
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [fllr_pkg::VAL_W-1:0]    s_axis_tdata,    // [31:0] value
    input  wire [fllr_pkg::OP_W-1:0]     s_axis_tuser,    // [1:0] opcode
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [fllr_pkg::OUT_W-1:0]   m_axis_tdata,    // [31:0] taken_value,
                                                          // [36:32] length, pad
    output logic [fllr_pkg::ST_W-1:0]    m_axis_tuser     // [1:0] status
);
    import fllr_pkg::*;

    logic              r_stack_mode;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_taken;
    logic [LEN_W-1:0]  r_len;
    t_status           r_status;
    t_status           n_status;
    logic [VAL_W-1:0]  n_taken;

    logic              w_accept;
    logic [DATA_W-1:0] w_value;
    logic              w_full;
    logic              w_empty;
    logic              w_ins;
    logic              w_take;
    logic              w_rem;

    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH:0]    w_hit;
    t_cell_ctl         w_ctl  [DEPTH];

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_value       = s_axis_tdata[DATA_W-1:0];
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_hit[0]      = 1'b0;

    always_comb begin
        w_ins    = 1'b0;
        w_take   = 1'b0;
        w_rem    = 1'b0;
        n_count  = r_count;
        n_status = ST_MISS;
        n_taken  = '0;
        case (t_opcode'(s_axis_tuser))
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins    = w_accept;
                    n_count  = r_count + CNT_W'(1);
                    n_status = ST_OK;
                end
            end
            OP_TAKE: begin
                if (!w_empty) begin
                    w_take   = w_accept;
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_OK;
                    n_taken  = VAL_W'(w_data[0]);
                end
            end
            OP_REMOVE: begin
                if (w_hit[DEPTH]) begin
                    w_rem    = w_accept;
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_OK;
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_value;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_data[g];
        end else begin : g_body
            assign w_right = w_data[g+1];
        end

        always_comb begin
            w_ctl[g].occupied   = (CNT_W'(g) < r_count);
            w_ctl[g].load_value = w_ins &&
                                  (r_stack_mode ? (g == 0) : (r_count == CNT_W'(g)));
            w_ctl[g].load_left  = w_ins && r_stack_mode;
            w_ctl[g].load_right = w_take;
            w_ctl[g].remove_en  = w_rem;
        end

        fllr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_hit   (w_hit[g]),
            .o_hit   (w_hit[g+1]),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_mode <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stack_mode <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_taken  <= n_taken;
            r_len    <= LEN_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_W'({r_len, r_taken});

endmodule

`default_nettype wire

/* rtl/fllr_chk.sv */
// ----------------------------------------------------------------------------
// fllr_chk
// Port-level checks for the queue/stack store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fllr_chk (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tready,
    input  wire                          m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire [fllr_pkg::OUT_W-1:0]    m_axis_tdata,
    input  wire [fllr_pkg::ST_W-1:0]     m_axis_tuser
);
    import fllr_pkg::*;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[VAL_W +: LEN_W] <= LEN_W'(DEPTH)))
        else $error("length beyond depth");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL))
            |-> (m_axis_tdata[VAL_W +: LEN_W] == LEN_W'(DEPTH)))
        else $error("full status with room left");

    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[VAL_W-1:0] != '0)) |-> (m_axis_tuser == ST_OK))
        else $error("taken value on a failed operation");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind fifo_lifo_with_remove_by_value_unit fllr_chk u_fllr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
